// ===== hw/rtl/ucp_pkg.sv =====
// ucp_pkg: shared types, constants and helper functions for the UART RGB command parser.
// No dependencies; imported by ucp_ctrl, ucp_dp and uart_rgb_command_parser.

package ucp_pkg;

	localparam int LINE_CHARS = 12;
	localparam int IDX_W      = $clog2(LINE_CHARS);
	localparam int CNT_W      = $clog2(LINE_CHARS + 1);

	// event kinds
	localparam logic [2:0] KIND_ECHO       = 3'd0;
	localparam logic [2:0] KIND_ERASE      = 3'd1;
	localparam logic [2:0] KIND_RAINBOW_ON = 3'd2;
	localparam logic [2:0] KIND_LEDS       = 3'd3;
	localparam logic [2:0] KIND_ERROR      = 3'd4;
	localparam logic [2:0] KIND_FRAME      = 3'd5;

	// item command codes
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// character codes
	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_DEL   = 8'd127;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_HASH  = 8'h23;
	localparam logic [7:0] CHAR_D     = 8'h44;
	localparam logic [7:0] CHAR_SIX   = 8'h36;
	localparam logic [7:0] CHAR_EIGHT = 8'h38;

	// colour line layout: '#', six hex digits, 'D', led digit
	localparam int POS_HASH    = 0;
	localparam int POS_HEX_LO  = 1;
	localparam int POS_HEX_HI  = 6;
	localparam int POS_D       = 7;
	localparam int POS_LED     = 8;
	localparam int RAINBOW_LEN = 12;

	localparam logic [7:0] RAINBOW_WORD [RAINBOW_LEN] = '{
		8'h23, 8'h46, 8'h55, 8'h4C, 8'h4C, 8'h52,
		8'h41, 8'h49, 8'h4E, 8'h42, 8'h4F, 8'h57
	};

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [7:0]  echo_byte;
		logic [23:0] led_first;
		logic [23:0] led_second;
		logic [23:0] led_third;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic do_tick;
		logic do_erase;
		logic do_echo;
		logic scan_start;
		logic scan_step;
		logic do_line_end;
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic item_avail;
		logic is_tick;
		logic is_cr;
		logic is_del;
		logic line_empty;
		logic line_full;
		logic rainbow_on;
		logic scan_last;
		logic out_free;
	} dp_status_t;

	// upper-case hex digit: {valid, value}
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c[3:0] + 4'd9)};
		end
		return r;
	endfunction

	// colour wheel, 0xRRGGBB
	function automatic logic [23:0] wheel_colour(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
		logic [23:0] r;
		p = 8'd255 - pos;
		if (p < 8'd85) begin
			q = p;
		end else if (p < 8'd170) begin
			q = p - 8'd85;
		end else begin
			q = p - 8'd170;
		end
		t = 8'(q * 8'd3);
		if (p < 8'd85) begin
			r = {8'd255 - t, 8'd0, t};
		end else if (p < 8'd170) begin
			r = {8'd0, t, 8'd255 - t};
		end else begin
			r = {t, 8'd255 - t, 8'd0};
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ucp_ctrl.sv =====
// ucp_ctrl: sequencing state machine of the command parser.
// Depends on ucp_pkg; drives ucp_dp through dp_cmd_t and reads dp_status_t.

module ucp_ctrl import ucp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				// leave idle only when an item is actually taken
				if (status.item_avail) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (status.is_tick) begin
					if (status.rainbow_on) begin
						cmd.do_tick = 1'b1;
						state_d     = ST_EMIT;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (status.is_cr) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else if (status.is_del) begin
					if (status.line_empty) begin
						state_d = ST_IDLE;
					end else begin
						cmd.do_erase = 1'b1;
						state_d      = ST_EMIT;
					end
				end else begin
					if (status.line_full) begin
						state_d = ST_IDLE;
					end else begin
						cmd.do_echo = 1'b1;
						state_d     = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.do_line_end = 1'b1;
				state_d         = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/ucp_dp.sv =====
// ucp_dp: line store, LED colours, rainbow state, line scanner and output register.
// Depends on ucp_pkg; commanded by ucp_ctrl.

module ucp_dp import ucp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	input  logic       item_valid,
	input  in_item_t   item,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result
);

	in_item_t        item_q;
	logic [7:0]      store_q [LINE_CHARS];
	logic [CNT_W-1:0] fill_q;
	logic [23:0]     leds_q [3];
	logic            rainbow_q;
	logic [7:0]      wheel_q;

	// scanner
	logic [IDX_W-1:0] idx_q;
	logic             ended_q;
	logic             rainbow_ok_q;
	logic             colour_ok_q;
	logic [23:0]      rgb_q;
	logic [1:0]       sel_q;

	out_item_t res_q;
	out_item_t res_d;
	out_item_t out_q;
	logic      out_valid_q;

	logic [7:0]  ch;
	logic        in_text;
	logic [4:0]  nib;
	logic        rainbow_step;
	logic        colour_step;
	logic [23:0] led_new [3];

	assign ch      = store_q[idx_q];
	assign in_text = !ended_q && (CNT_W'(idx_q) < fill_q) && (ch != CHAR_NUL);
	assign nib     = hex_nibble(ch);

	always_comb begin
		rainbow_step = 1'b1;
		if (idx_q < IDX_W'(RAINBOW_LEN)) begin
			rainbow_step = in_text && (ch == RAINBOW_WORD[idx_q[3:0]]);
		end else if (idx_q == IDX_W'(RAINBOW_LEN)) begin
			rainbow_step = !in_text;
		end
	end

	always_comb begin
		if (idx_q == IDX_W'(POS_HASH)) begin
			colour_step = in_text && (ch == CHAR_HASH);
		end else if (idx_q <= IDX_W'(POS_HEX_HI)) begin
			colour_step = in_text && nib[4];
		end else if (idx_q == IDX_W'(POS_D)) begin
			colour_step = in_text && (ch == CHAR_D);
		end else if (idx_q == IDX_W'(POS_LED)) begin
			colour_step = in_text && (ch >= CHAR_SIX) && (ch <= CHAR_EIGHT);
		end else begin
			colour_step = !in_text || (ch == CHAR_SPACE);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			led_new[i] = (sel_q == 2'(i)) ? rgb_q : leds_q[i];
		end
	end

	assign status.item_avail = item_valid;
	assign status.is_tick    = (item_q.cmd == CMD_TICK);
	assign status.is_cr      = (item_q.rx_byte == CHAR_CR);
	assign status.is_del     = (item_q.rx_byte == CHAR_DEL);
	assign status.line_empty = (fill_q == '0);
	assign status.line_full  = (fill_q >= CNT_W'(LINE_CHARS));
	assign status.rainbow_on = rainbow_q;
	assign status.scan_last  = (idx_q == IDX_W'(LINE_CHARS - 1));
	assign status.out_free   = !out_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.take && item_valid) begin
			item_q <= item;
		end
	end

	// line, LEDs, rainbow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_CHARS; i++) begin
				store_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				leds_q[i] <= '0;
			end
			fill_q    <= '0;
			rainbow_q <= 1'b0;
			wheel_q   <= '0;
		end else begin
			if (cmd.do_tick) begin
				wheel_q <= wheel_q + 8'd1;
			end
			if (cmd.do_echo) begin
				store_q[fill_q[IDX_W-1:0]] <= item_q.rx_byte;
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.do_erase) begin
				store_q[IDX_W'(fill_q - CNT_W'(1))] <= '0;
				fill_q <= fill_q - CNT_W'(1);
			end
			if (cmd.do_line_end) begin
				if (rainbow_ok_q) begin
					rainbow_q <= 1'b1;
				end else if (colour_ok_q) begin
					leds_q[sel_q] <= rgb_q;
					rainbow_q     <= 1'b0;
				end
				for (int i = 0; i < LINE_CHARS; i++) begin
					store_q[i] <= '0;
				end
				fill_q <= '0;
			end
		end
	end

	// scanner walks the whole line one character per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			ended_q      <= 1'b0;
			rainbow_ok_q <= 1'b0;
			colour_ok_q  <= 1'b0;
			sel_q        <= '0;
		end else if (cmd.scan_start) begin
			idx_q        <= '0;
			ended_q      <= 1'b0;
			rainbow_ok_q <= 1'b1;
			colour_ok_q  <= 1'b1;
		end else if (cmd.scan_step) begin
			idx_q        <= status.scan_last ? '0 : idx_q + IDX_W'(1);
			ended_q      <= ended_q || !in_text;
			rainbow_ok_q <= rainbow_ok_q && rainbow_step;
			colour_ok_q  <= colour_ok_q && colour_step;
			if (idx_q == IDX_W'(POS_LED)) begin
				sel_q <= 2'(ch - CHAR_SIX);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && idx_q >= IDX_W'(POS_HEX_LO) && idx_q <= IDX_W'(POS_HEX_HI)) begin
			rgb_q <= {rgb_q[19:0], nib[3:0]};
		end
	end

	// pending result
	always_comb begin
		res_d = res_q;
		if (cmd.do_tick) begin
			res_d            = '0;
			res_d.event_kind = KIND_FRAME;
			res_d.led_first  = wheel_colour(wheel_q);
			res_d.led_second = res_d.led_first;
			res_d.led_third  = res_d.led_first;
		end else if (cmd.do_echo) begin
			res_d            = '0;
			res_d.event_kind = KIND_ECHO;
			res_d.echo_byte  = item_q.rx_byte;
		end else if (cmd.do_erase) begin
			res_d            = '0;
			res_d.event_kind = KIND_ERASE;
		end else if (cmd.do_line_end) begin
			res_d = '0;
			priority if (rainbow_ok_q) begin
				res_d.event_kind = KIND_RAINBOW_ON;
			end else if (colour_ok_q) begin
				res_d.event_kind = KIND_LEDS;
				res_d.led_first  = led_new[0];
				res_d.led_second = led_new[1];
				res_d.led_third  = led_new[2];
			end else begin
				res_d.event_kind = KIND_ERROR;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== hw/rtl/uart_rgb_command_parser.sv =====
// uart_rgb_command_parser: line-oriented colour command parser for three RGB LEDs.
// Channels: item (cmd, rx_byte) in, result (event_kind, echo_byte, three LED colours) out,
// both valid/ready; an item is taken when item_valid and item_ready are high at a clock edge.
// cmd 0 is a received character, cmd 1 a rainbow timer tick. Each item gives one result
// or none (full line, erase of an empty line, tick with rainbow mode off).
// Flow: one item at a time. A character or tick passes the decode state, then its result
// is loaded into the output register once that is free, raising result_valid; item_ready
// rises at the same time, so the next item goes in once the result is loaded. A carriage
// return walks all LINE_CHARS line positions one character per cycle, then ends the line
// and loads its result. Items with no result free the block straight from decode.
// The result sits in an output register: the next item is accepted while it waits;
// that item's result holds in the datapath until the register is taken.
// Reset clears the line, the LED colours, rainbow mode and the wheel position,
// and drops any pending result.
// Depends on ucp_pkg, ucp_ctrl and ucp_dp.

module uart_rgb_command_parser import ucp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ucp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	assign item_ready = cmd.take;

	ucp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.item_valid   (item_valid),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
